FILE: src/hct_pkg.sv
// ----------------------------------------------------------------------------
// Highly composite test package
// Shared constants for the highly composite number test block.
// ----------------------------------------------------------------------------
package hct_pkg;

   localparam int DEFAULT_VALUE_WIDTH = 12;

endpackage

FILE: src/hct_rem.sv
// ----------------------------------------------------------------------------
// Serial remainder unit
// Restoring division that takes one quotient digit per cycle and reports
// whether the dividend is an exact multiple of the divisor.
// ----------------------------------------------------------------------------
module hct_rem #(
   parameter int VALUE_WIDTH = hct_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [VALUE_WIDTH-1:0] dividend,
   input  logic [VALUE_WIDTH-1:0] divisor,
   output logic                   done,
   output logic                   rem_zero
);
   import hct_pkg::*;

   localparam int CNT_WIDTH = $clog2(VALUE_WIDTH + 1);

   logic [VALUE_WIDTH-1:0] dvd_ff;
   logic [VALUE_WIDTH-1:0] dsr_ff;
   logic [VALUE_WIDTH-1:0] rem_ff;
   logic [CNT_WIDTH-1:0]   cnt_ff;
   logic                   busy_ff;
   logic                   done_ff;
   logic [VALUE_WIDTH:0]   shifted;
   logic [VALUE_WIDTH:0]   diff;
   logic [VALUE_WIDTH-1:0] rem_in;

   always_comb begin
      shifted = {rem_ff, dvd_ff[VALUE_WIDTH-1]};
      diff    = shifted - {1'b0, dsr_ff};
      if (shifted >= {1'b0, dsr_ff}) begin
         rem_in = diff[VALUE_WIDTH-1:0];
      end else begin
         rem_in = shifted[VALUE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_WIDTH'(VALUE_WIDTH);
            dvd_ff  <= dividend;
            dsr_ff  <= divisor;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            dvd_ff <= {dvd_ff[VALUE_WIDTH-2:0], 1'b0};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_WIDTH'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign rem_zero = (rem_ff == '0);

   a_rem_below_divisor : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < dsr_ff))
      else $error("Remainder is not below the divisor at completion.");

endmodule

FILE: src/hct_divcnt.sv
// ----------------------------------------------------------------------------
// Divisor counter
// Counts the divisors of an operand by trial division up to its square
// root, using the serial remainder unit for each trial.
// ----------------------------------------------------------------------------
module hct_divcnt #(
   parameter int VALUE_WIDTH = hct_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [VALUE_WIDTH-1:0] operand,
   output logic                   done,
   output logic [VALUE_WIDTH-1:0] count
);
   import hct_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_WAIT
   } state_type;

   state_type              state_ff;
   logic [VALUE_WIDTH-1:0] m_ff;
   logic [VALUE_WIDTH-1:0] t_ff;
   logic [VALUE_WIDTH:0]   sq_ff;
   logic [VALUE_WIDTH-1:0] count_ff;
   logic                   done_ff;
   logic                   rem_start_ff;
   logic                   rem_done;
   logic                   rem_zero;
   logic [VALUE_WIDTH:0]   sq_in;
   logic                   sq_exact;

   assign sq_in    = sq_ff + {t_ff, 1'b1};
   assign sq_exact = (sq_ff == {1'b0, m_ff});

   hct_rem #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start_ff),
      .dividend (m_ff),
      .divisor  (t_ff),
      .done     (rem_done),
      .rem_zero (rem_zero)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         done_ff      <= 1'b0;
         rem_start_ff <= 1'b0;
      end else begin
         done_ff      <= 1'b0;
         rem_start_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  m_ff     <= operand;
                  t_ff     <= VALUE_WIDTH'(1);
                  sq_ff    <= (VALUE_WIDTH + 1)'(1);
                  count_ff <= '0;
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               if (sq_ff > {1'b0, m_ff}) begin
                  done_ff  <= 1'b1;
                  state_ff <= ST_IDLE;
               end else begin
                  rem_start_ff <= 1'b1;
                  state_ff     <= ST_WAIT;
               end
            end
            ST_WAIT: begin
               if (rem_done) begin
                  if (rem_zero) begin
                     count_ff <= count_ff + (sq_exact ? VALUE_WIDTH'(1) : VALUE_WIDTH'(2));
                  end
                  sq_ff    <= sq_in;
                  t_ff     <= t_ff + 1'b1;
                  state_ff <= ST_CHECK;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign done  = done_ff;
   assign count = count_ff;

   a_trial_nonzero : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WAIT) |-> (t_ff != '0))
      else $error("Trial divisor is zero during a remainder step.");

   a_count_nonzero : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (count_ff != '0))
      else $error("A positive operand reported no divisors.");

endmodule

FILE: src/highly_composite_test.sv
// ----------------------------------------------------------------------------
// Highly composite number test
// Reports for each positive integer whether every smaller integer has
// strictly fewer divisors.
// ----------------------------------------------------------------------------
// The request channel carries one value per transfer on req_value; the
// response channel returns one flag per request on rsp_is_highly_composite.
// A value of zero answers 0 and a value of one answers 1.
// The block handles one value at a time. The divisors of an integer m are
// counted by trial division up to floor(sqrt(m)) in the serial remainder
// unit, which resolves one quotient bit per cycle. The value's own count
// is taken first, then the smaller integers are counted in rising order
// until one reaches that count or all of them have been counted.
// req_ready is high whenever no value is in progress, also while a result
// still waits on the response side. If the receiver stalls, the finished
// flag is held in the block until the output register is free. Reset
// clears the control state and drops both handshakes.
// ----------------------------------------------------------------------------
module highly_composite_test #(
   parameter int VALUE_WIDTH = hct_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_is_highly_composite
);
   import hct_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TARGET,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type              state_ff;
   logic [VALUE_WIDTH-1:0] v_ff;
   logic [VALUE_WIDTH-1:0] j_ff;
   logic [VALUE_WIDTH-1:0] target_ff;
   logic                   flag_ff;
   logic                   dc_start_ff;
   logic [VALUE_WIDTH-1:0] dc_m_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_flag_ff;
   logic                   dc_done;
   logic [VALUE_WIDTH-1:0] dc_count;
   logic [VALUE_WIDTH-1:0] j_in;

   assign j_in = j_ff + 1'b1;

   hct_divcnt #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_divcnt (
      .clock   (clock),
      .reset   (reset),
      .start   (dc_start_ff),
      .operand (dc_m_ff),
      .done    (dc_done),
      .count   (dc_count)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dc_start_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dc_start_ff <= 1'b0;
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  v_ff <= req_value;
                  if (req_value == '0) begin
                     flag_ff  <= 1'b0;
                     state_ff <= ST_DONE;
                  end else begin
                     dc_m_ff     <= req_value;
                     dc_start_ff <= 1'b1;
                     state_ff    <= ST_TARGET;
                  end
               end
            end
            ST_TARGET: begin
               if (dc_done) begin
                  target_ff <= dc_count;
                  if (v_ff == VALUE_WIDTH'(1)) begin
                     flag_ff  <= 1'b1;
                     state_ff <= ST_DONE;
                  end else begin
                     j_ff        <= VALUE_WIDTH'(1);
                     dc_m_ff     <= VALUE_WIDTH'(1);
                     dc_start_ff <= 1'b1;
                     state_ff    <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               if (dc_done) begin
                  if (dc_count >= target_ff) begin
                     flag_ff  <= 1'b0;
                     state_ff <= ST_DONE;
                  end else if (j_in == v_ff) begin
                     flag_ff  <= 1'b1;
                     state_ff <= ST_DONE;
                  end else begin
                     j_ff        <= j_in;
                     dc_m_ff     <= j_in;
                     dc_start_ff <= 1'b1;
                  end
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_flag_ff  <= flag_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready               = (state_ff == ST_IDLE) && !reset;
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_is_highly_composite = rsp_flag_ff;

   a_zero_goes_to_done : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_value == '0)) |=> (state_ff == ST_DONE))
      else $error("A zero value did not go straight to the result.");

   a_count_while_busy : assert property (@(posedge clock) disable iff (reset)
      dc_done |-> ((state_ff == ST_TARGET) || (state_ff == ST_SCAN)))
      else $error("Divisor count finished while no value was in progress.");

   a_scan_below_value : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (j_ff < v_ff))
      else $error("Scan reached the tested value.");

endmodule
